// ----- rtl/core/sogr_pkg.sv -----
// Shared types, constants and the sine table function for the glide oscillator.
package sogr_pkg;

	// Field widths
	localparam int FREQ_W   = 21;
	localparam int LEVEL_W  = 15;
	localparam int LEN_W    = 7;
	localparam int RATE_W   = 18;
	localparam int PHASE_W  = 32;
	localparam int SAMPLE_W = 16;

	// Parameter defaults
	localparam int MAX_BLOCK_DEF  = 64;
	localparam int SINE_DEPTH_DEF = 1024;

	// Reset values and limits
	localparam logic [RATE_W-1:0]  RATE_RST  = RATE_W'(48000);
	localparam logic [FREQ_W-1:0]  FREQ_RST  = FREQ_W'(128000);
	localparam logic [LEVEL_W-1:0] LEVEL_RST = LEVEL_W'(8192);
	localparam logic [LEVEL_W-1:0] LEVEL_MAX = LEVEL_W'(16384);

	// Frequency is in 1/256 Hz, so step = freq * 2^24 / rate
	localparam int STEP_SHIFT = 24;

	// Shared divider: 46-bit dividend holds (freq + 1) << 24
	localparam int DIV_NW = FREQ_W + 1 + STEP_SHIFT;
	localparam int DIV_DW = RATE_W;
	localparam int DIV_CW = $clog2(DIV_NW);

	// Polynomial sine coefficients in Q30
	localparam longint Q30_ONE = 64'sd1073741824;
	localparam longint POLY_A  = 64'sd1686629713;
	localparam longint POLY_B  = 64'sd688904866;
	localparam longint POLY_C  = 64'sd76016977;

	typedef struct packed {
		logic [FREQ_W-1:0]  target_freq;
		logic [LEVEL_W-1:0] target_level;
		logic [LEN_W-1:0]   block_len;
	} req_t;

	typedef struct packed {
		logic signed [SAMPLE_W-1:0] sample;
		logic                       last;
	} smp_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_PREP,
		ST_DIV_G,
		ST_DIV_F,
		ST_DIV_S,
		ST_DIV_D0,
		ST_DIV_D1,
		ST_IDX,
		ST_ROM,
		ST_MUL,
		ST_EMIT
	} state_t;

	typedef enum logic [2:0] {
		OP_GAIN,
		OP_FREQ,
		OP_BASE,
		OP_INC0,
		OP_INC1
	} div_op_t;

	typedef struct packed {
		logic    load;
		logic    div_start;
		div_op_t div_op;
		logic    init;
		logic    sample;
		logic    step;
		logic    phase;
		logic    emit;
		logic    commit;
	} cmd_t;

	typedef struct packed {
		logic req_empty;
		logic div_done;
		logic out_free;
		logic last;
	} sts_t;

	// Table value for phase u (a 32-bit turn fraction), full scale 2^(sw-1)-1
	function automatic longint sine_from_u(longint u, int sw);
		longint x;
		longint ax;
		longint x2;
		longint inner;
		longint mid;
		longint y;
		longint amp;
		logic   neg;
		x = u[31] ? u - 64'sd4294967296 : u;
		// Fold onto the quarter wave
		if (x > Q30_ONE) begin
			x = 2 * Q30_ONE - x;
		end else if (x < -Q30_ONE) begin
			x = -2 * Q30_ONE - x;
		end
		neg   = x < 0;
		ax    = neg ? -x : x;
		x2    = (ax * ax) >>> 30;
		inner = POLY_B - ((POLY_C * x2) >>> 30);
		mid   = POLY_A - ((x2 * inner) >>> 30);
		y     = (ax * mid) >>> 30;
		amp   = (longint'(1) <<< (sw - 1)) - 1;
		y     = (y * amp + (longint'(1) <<< 29)) >>> 30;
		return neg ? -y : y;
	endfunction

endpackage

// ----- rtl/core/sogr_div.sv -----
// Restoring divider, one quotient bit per cycle, shared by all block setup divisions.
module sogr_div (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             start,
	input  logic [sogr_pkg::DIV_NW-1:0]      dividend,
	input  logic [sogr_pkg::DIV_DW-1:0]      divisor,
	output logic                             done,
	output logic [sogr_pkg::DIV_NW-1:0]      quotient,
	output logic [sogr_pkg::DIV_DW-1:0]      remainder
);

	localparam int NW = sogr_pkg::DIV_NW;
	localparam int DW = sogr_pkg::DIV_DW;
	localparam int CW = sogr_pkg::DIV_CW;

	logic          busy_q;
	logic          done_q;
	logic [CW-1:0] cnt_q;
	logic [NW-1:0] quo_q;
	logic [DW-1:0] rem_q;
	logic [DW-1:0] dvs_q;
	logic [DW:0]   trial;
	logic          fits;

	// Shift the next dividend bit into the partial remainder and try a subtract
	assign trial = {rem_q, quo_q[NW-1]};
	assign fits  = trial >= {1'b0, dvs_q};

	// Control: count the steps, pulse done after the last one
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CW'(NW - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Datapath: load operands, then one restoring step per cycle
	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			dvs_q <= divisor;
		end else if (busy_q) begin
			quo_q <= {quo_q[NW-2:0], fits};
			rem_q <= fits ? DW'(trial - {1'b0, dvs_q}) : DW'(trial);
		end
	end

	assign done      = done_q;
	assign quotient  = quo_q;
	assign remainder = rem_q;

endmodule

// ----- rtl/core/sogr_ctrl.sv -----
// Sequencer: block setup divisions, then the per-sample lookup, scale and emit steps.
module sogr_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            req_valid,
	output logic            req_stall,
	input  sogr_pkg::sts_t  sts,
	output sogr_pkg::cmd_t  cmd
);

	sogr_pkg::state_t state_q;
	sogr_pkg::state_t state_d;

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= sogr_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state and commands
	always_comb begin
		state_d    = state_q;
		cmd        = '0;
		cmd.div_op = sogr_pkg::OP_GAIN;
		req_stall  = 1'b1;
		case (state_q)
			sogr_pkg::ST_IDLE: begin
				req_stall = 1'b0;
				// Empty blocks are taken and dropped
				if (req_valid && !sts.req_empty) begin
					cmd.load = 1'b1;
					state_d  = sogr_pkg::ST_PREP;
				end
			end
			sogr_pkg::ST_PREP: begin
				cmd.div_start = 1'b1;
				cmd.div_op    = sogr_pkg::OP_GAIN;
				state_d       = sogr_pkg::ST_DIV_G;
			end
			sogr_pkg::ST_DIV_G: begin
				if (sts.div_done) begin
					cmd.div_start = 1'b1;
					cmd.div_op    = sogr_pkg::OP_FREQ;
					state_d       = sogr_pkg::ST_DIV_F;
				end
			end
			sogr_pkg::ST_DIV_F: begin
				if (sts.div_done) begin
					cmd.div_start = 1'b1;
					cmd.div_op    = sogr_pkg::OP_BASE;
					state_d       = sogr_pkg::ST_DIV_S;
				end
			end
			sogr_pkg::ST_DIV_S: begin
				if (sts.div_done) begin
					cmd.div_start = 1'b1;
					cmd.div_op    = sogr_pkg::OP_INC0;
					state_d       = sogr_pkg::ST_DIV_D0;
				end
			end
			sogr_pkg::ST_DIV_D0: begin
				if (sts.div_done) begin
					cmd.div_start = 1'b1;
					cmd.div_op    = sogr_pkg::OP_INC1;
					state_d       = sogr_pkg::ST_DIV_D1;
				end
			end
			sogr_pkg::ST_DIV_D1: begin
				if (sts.div_done) begin
					cmd.init = 1'b1;
					state_d  = sogr_pkg::ST_IDX;
				end
			end
			sogr_pkg::ST_IDX: begin
				cmd.sample = 1'b1;
				state_d    = sogr_pkg::ST_ROM;
			end
			sogr_pkg::ST_ROM: begin
				cmd.step = 1'b1;
				state_d  = sogr_pkg::ST_MUL;
			end
			sogr_pkg::ST_MUL: begin
				cmd.phase = 1'b1;
				state_d   = sogr_pkg::ST_EMIT;
			end
			sogr_pkg::ST_EMIT: begin
				// Hold until the output register can take the word
				if (sts.out_free) begin
					cmd.emit = 1'b1;
					if (sts.last) begin
						cmd.commit = 1'b1;
						state_d    = sogr_pkg::ST_IDLE;
					end else begin
						state_d = sogr_pkg::ST_IDX;
					end
				end
			end
			default: begin
				state_d = sogr_pkg::ST_IDLE;
			end
		endcase
	end

endmodule

// ----- rtl/core/sogr_dp.sv -----
// Datapath: glide and ramp accumulators, phase accumulator, sine ROM, gain multiply, output register.
module sogr_dp #(
	parameter int MAX_BLOCK        = sogr_pkg::MAX_BLOCK_DEF,
	parameter int SINE_TABLE_DEPTH = sogr_pkg::SINE_DEPTH_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  sogr_pkg::req_t                 req,
	input  logic                           cfg_we,
	input  logic [sogr_pkg::RATE_W-1:0]    cfg_data,
	input  sogr_pkg::cmd_t                 cmd,
	output sogr_pkg::sts_t                 sts,
	output logic                           smp_valid,
	input  logic                           smp_stall,
	output sogr_pkg::smp_t                 smp
);

	localparam int FW  = sogr_pkg::FREQ_W;
	localparam int LW  = sogr_pkg::LEVEL_W;
	localparam int RW  = sogr_pkg::RATE_W;
	localparam int PW  = sogr_pkg::PHASE_W;
	localparam int SW  = sogr_pkg::SAMPLE_W;
	localparam int NWD = sogr_pkg::DIV_NW;
	localparam int DWD = sogr_pkg::DIV_DW;
	localparam int SH  = sogr_pkg::STEP_SHIFT;
	localparam int NW  = $clog2(MAX_BLOCK + 1);
	localparam int IW  = (SINE_TABLE_DEPTH > 1) ? $clog2(SINE_TABLE_DEPTH) : 1;
	localparam int XW  = PW + IW + 1;
	localparam int MW  = SW + LW;

	// Architectural state
	logic [RW-1:0] rate_q;
	logic [PW-1:0] phase_q;
	logic [FW-1:0] cur_f_q;
	logic [LW-1:0] cur_g_q;

	// Block request
	logic [FW-1:0] tgt_f_q;
	logic [LW-1:0] tgt_g_q;
	logic [NW-1:0] n_q;
	logic [NW-1:0] cnt_q;

	// Setup division results
	sogr_pkg::div_op_t op_q;
	logic [LW-1:0] qg_q;
	logic [NW-1:0] rg_q;
	logic [FW-1:0] qf_q;
	logic [NW-1:0] rf_q;
	logic [PW-1:0] base_step_q;
	logic [RW-1:0] base_rem_q;
	logic [PW-1:0] dq0_q;
	logic [RW-1:0] dr0_q;
	logic [PW-1:0] dq1_q;
	logic [RW-1:0] dr1_q;

	// Running glide state
	logic [LW-1:0] gq_q;
	logic [NW-1:0] gr_q;
	logic [NW-1:0] fr_q;
	logic [PW-1:0] step_q;
	logic [RW-1:0] srem_q;

	// Sample pipeline
	logic [IW-1:0]          idx_s1;
	logic [LW-1:0]          gain_s1;
	logic                   last_s1;
	logic signed [SW-1:0]   rom_s2;
	logic [LW-1:0]          gain_s2;
	logic                   last_s2;
	logic [MW-1:0]          prod_s3;
	logic                   neg_s3;
	logic                   last_s3;

	// Output register
	logic                   smp_valid_q;
	sogr_pkg::smp_t         smp_q;

	// Divider hookup
	logic [NWD-1:0] div_dvd;
	logic [DWD-1:0] div_dvs;
	logic           div_done;
	logic [NWD-1:0] div_quo;
	logic [DWD-1:0] div_rem;

	logic [LW-1:0]  lvl_sat;
	logic [NW-1:0]  len_c;
	logic           g_down;
	logic           f_down;
	logic [LW-1:0]  abs_g;
	logic [FW-1:0]  abs_f;
	logic [LW-1:0]  gain_now;

	logic [NW:0]    g_sum;
	logic           g_c;
	logic [NW:0]    f_sum;
	logic           f_c;
	logic [PW-1:0]  dq_sel;
	logic [RW-1:0]  dr_sel;
	logic [RW:0]    up_sum;
	logic           up_c;
	logic           dn_b;
	logic [RW-1:0]  srem_next;
	logic [PW-1:0]  step_next;

	logic [XW-1:0]  idx_prod;
	logic [SW-1:0]  mag_s2;
	logic [MW:0]    rnd;
	logic [SW-1:0]  vmag;
	logic [SW-1:0]  out_val;

	logic signed [SW-1:0] rom_w [SINE_TABLE_DEPTH];

	// Request fields: clamp the length, saturate the level
	assign lvl_sat = (req.target_level > sogr_pkg::LEVEL_MAX) ? sogr_pkg::LEVEL_MAX
		: req.target_level;
	assign len_c   = (req.block_len > sogr_pkg::LEN_W'(MAX_BLOCK)) ? NW'(MAX_BLOCK)
		: NW'(req.block_len);

	// Glide directions and spans
	assign g_down = tgt_g_q < cur_g_q;
	assign f_down = tgt_f_q < cur_f_q;
	assign abs_g  = g_down ? cur_g_q - tgt_g_q : tgt_g_q - cur_g_q;
	assign abs_f  = f_down ? cur_f_q - tgt_f_q : tgt_f_q - cur_f_q;

	// Select the operands of the next setup division
	always_comb begin
		div_dvd = '0;
		div_dvs = rate_q;
		case (cmd.div_op)
			sogr_pkg::OP_GAIN: begin
				div_dvd = NWD'(abs_g);
				div_dvs = DWD'(n_q);
			end
			sogr_pkg::OP_FREQ: begin
				div_dvd = NWD'(abs_f);
				div_dvs = DWD'(n_q);
			end
			sogr_pkg::OP_BASE: begin
				div_dvd = NWD'(cur_f_q) << SH;
			end
			sogr_pkg::OP_INC0: begin
				div_dvd = NWD'(qf_q) << SH;
			end
			sogr_pkg::OP_INC1: begin
				div_dvd = (NWD'(qf_q) + NWD'(1)) << SH;
			end
			default: begin
				div_dvd = '0;
			end
		endcase
	end

	sogr_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (cmd.div_start),
		.dividend  (div_dvd),
		.divisor   (div_dvs),
		.done      (div_done),
		.quotient  (div_quo),
		.remainder (div_rem)
	);

	// Advance the ramp: quotient and remainder of |dg|*k/n
	assign g_sum = {1'b0, gr_q} + {1'b0, rg_q};
	assign g_c   = g_sum >= {1'b0, n_q};

	// Advance the glide: the frequency moves by qf or qf+1 this sample
	assign f_sum  = {1'b0, fr_q} + {1'b0, rf_q};
	assign f_c    = f_sum >= {1'b0, n_q};
	assign dq_sel = f_c ? dq1_q : dq0_q;
	assign dr_sel = f_c ? dr1_q : dr0_q;

	// Track step = floor(f * 2^24 / rate) with its remainder
	assign up_sum = {1'b0, srem_q} + {1'b0, dr_sel};
	assign up_c   = up_sum >= {1'b0, rate_q};
	assign dn_b   = srem_q < dr_sel;

	always_comb begin
		if (f_down) begin
			srem_next = dn_b ? RW'({1'b0, srem_q} + {1'b0, rate_q} - {1'b0, dr_sel})
				: srem_q - dr_sel;
			step_next = step_q - dq_sel - PW'(dn_b);
		end else begin
			srem_next = up_c ? RW'(up_sum - {1'b0, rate_q}) : RW'(up_sum);
			step_next = step_q + dq_sel + PW'(up_c);
		end
	end

	// Gain for the current sample
	assign gain_now = g_down ? cur_g_q - gq_q : cur_g_q + gq_q;

	// Table index from the phase
	assign idx_prod = XW'(phase_q) * XW'(SINE_TABLE_DEPTH);

	// Sine ROM contents, built at elaboration
	for (genvar gi = 0; gi < SINE_TABLE_DEPTH; gi++) begin : g_rom
		localparam longint U = (longint'(gi) << 32) / SINE_TABLE_DEPTH;
		assign rom_w[gi] = SW'(sogr_pkg::sine_from_u(U, SW));
	end

	// Scale the magnitude, round half up, restore the sign
	assign mag_s2  = rom_s2[SW-1] ? SW'(-rom_s2) : SW'(rom_s2);
	assign rnd     = {1'b0, prod_s3} + (MW + 1)'(32'd32768);
	assign vmag    = rnd[MW:MW+1-SW];
	assign out_val = neg_s3 ? SW'(-vmag) : vmag;

	// Configuration and architectural state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rate_q  <= sogr_pkg::RATE_RST;
			phase_q <= '0;
			cur_f_q <= sogr_pkg::FREQ_RST;
			cur_g_q <= sogr_pkg::LEVEL_RST;
		end else begin
			if (cfg_we) begin
				rate_q <= cfg_data;
			end
			if (cmd.phase) begin
				phase_q <= phase_q + ((rate_q == '0) ? PW'(0) : step_q);
			end
			if (cmd.commit) begin
				cur_f_q <= tgt_f_q;
				cur_g_q <= tgt_g_q;
			end
		end
	end

	// Capture the request, latch division results, run the glide
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			tgt_f_q <= req.target_freq;
			tgt_g_q <= lvl_sat;
			n_q     <= len_c;
		end
		if (cmd.div_start) begin
			op_q <= cmd.div_op;
		end
		if (div_done) begin
			case (op_q)
				sogr_pkg::OP_GAIN: begin
					qg_q <= div_quo[LW-1:0];
					rg_q <= div_rem[NW-1:0];
				end
				sogr_pkg::OP_FREQ: begin
					qf_q <= div_quo[FW-1:0];
					rf_q <= div_rem[NW-1:0];
				end
				sogr_pkg::OP_BASE: begin
					base_step_q <= div_quo[PW-1:0];
					base_rem_q  <= div_rem;
				end
				sogr_pkg::OP_INC0: begin
					dq0_q <= div_quo[PW-1:0];
					dr0_q <= div_rem;
				end
				sogr_pkg::OP_INC1: begin
					dq1_q <= div_quo[PW-1:0];
					dr1_q <= div_rem;
				end
				default: begin
					qg_q <= qg_q;
				end
			endcase
		end
		if (cmd.init) begin
			gq_q   <= '0;
			gr_q   <= '0;
			fr_q   <= '0;
			step_q <= base_step_q;
			srem_q <= base_rem_q;
			cnt_q  <= n_q;
		end else begin
			if (cmd.step) begin
				gr_q   <= g_c ? NW'(g_sum - {1'b0, n_q}) : NW'(g_sum);
				gq_q   <= gq_q + qg_q + LW'(g_c);
				fr_q   <= f_c ? NW'(f_sum - {1'b0, n_q}) : NW'(f_sum);
				step_q <= step_next;
				srem_q <= srem_next;
			end
			if (cmd.emit) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	// Sample pipeline: index and gain, ROM read, multiply
	always_ff @(posedge clk) begin
		if (cmd.sample) begin
			idx_s1  <= idx_prod[PW +: IW];
			gain_s1 <= gain_now;
			last_s1 <= cnt_q == NW'(1);
		end
		rom_s2  <= rom_w[idx_s1];
		gain_s2 <= gain_s1;
		last_s2 <= last_s1;
		prod_s3 <= MW'(mag_s2) * MW'(gain_s2);
		neg_s3  <= rom_s2[SW-1];
		last_s3 <= last_s2;
	end

	// Output register: load a new word, drop it once taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			smp_valid_q <= 1'b0;
		end else if (cmd.emit) begin
			smp_valid_q <= 1'b1;
		end else if (!smp_stall) begin
			smp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			smp_q.sample <= out_val;
			smp_q.last   <= last_s3;
		end
	end

	assign smp_valid     = smp_valid_q;
	assign smp           = smp_q;
	assign sts.req_empty = req.block_len == '0;
	assign sts.div_done  = div_done;
	assign sts.out_free  = !smp_valid_q || !smp_stall;
	assign sts.last      = last_s3;

endmodule

// ----- rtl/core/sine_oscillator_glide_gain_ramp.sv -----
// Top level of the DDS sine oscillator with frequency glide and gain ramp.
//
// Request channel (req_valid / req_stall / req): one word asks for one audio
// block of block_len samples toward a target frequency and level. A zero
// length word is taken and dropped; lengths above MAX_BLOCK are clipped.
// Sample channel (smp_valid / smp_stall / smp): one word per sample, with
// last set on the final sample of the block.
// Setup per block runs five divisions on one shared restoring divider at
// one bit per cycle. Each sample then steps through index, ROM read,
// multiply and emit.
// One block is in work at a time: req_stall is high from acceptance until
// the last sample is loaded into the output register.
// A stalled sample holds in the output register; the sequencer waits.
// Reset clears the phase, sets 500 Hz, gain 0.125 and a 48 kHz rate.
// cfg_we writes the sample rate; write it only while the block is idle.
module sine_oscillator_glide_gain_ramp #(
	parameter int MAX_BLOCK        = sogr_pkg::MAX_BLOCK_DEF,
	parameter int SINE_TABLE_DEPTH = sogr_pkg::SINE_DEPTH_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         req_valid,
	output logic                         req_stall,
	input  sogr_pkg::req_t               req,
	output logic                         smp_valid,
	input  logic                         smp_stall,
	output sogr_pkg::smp_t               smp,
	input  logic                         cfg_we,
	input  logic [sogr_pkg::RATE_W-1:0]  cfg_data
);

	sogr_pkg::cmd_t cmd;
	sogr_pkg::sts_t sts;

	sogr_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.sts       (sts),
		.cmd       (cmd)
	);

	sogr_dp #(
		.MAX_BLOCK        (MAX_BLOCK),
		.SINE_TABLE_DEPTH (SINE_TABLE_DEPTH)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.cfg_we    (cfg_we),
		.cfg_data  (cfg_data),
		.cmd       (cmd),
		.sts       (sts),
		.smp_valid (smp_valid),
		.smp_stall (smp_stall),
		.smp       (smp)
	);

endmodule

// ----- rtl/core/sogr_checker.sv -----
// Port-level checks for the glide oscillator, bound to the top level.
module sogr_checker (
	input logic                         clk,
	input logic                         arst_n,
	input logic                         req_valid,
	input logic                         req_stall,
	input sogr_pkg::req_t               req,
	input logic                         smp_valid,
	input logic                         smp_stall,
	input sogr_pkg::smp_t               smp,
	input logic                         cfg_we,
	input logic [sogr_pkg::RATE_W-1:0]  cfg_data
);

	// A stalled sample word holds
	a_smp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		smp_valid && smp_stall |=> smp_valid && $stable(smp))
		else $error("sample word changed while stalled");

	// A nonempty block closes the request channel
	a_busy_after_take: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && !req_stall && req.block_len != '0 |=> req_stall)
		else $error("request channel open after taking a block");

	// An empty block leaves the request channel open
	a_empty_drop: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && !req_stall && req.block_len == '0 |=> !req_stall)
		else $error("empty block closed the request channel");

	// No new request while a block is still mid-stream
	a_mid_block: assert property (@(posedge clk) disable iff (!arst_n)
		smp_valid && !smp.last |-> req_stall)
		else $error("request channel open in the middle of a block");

endmodule

bind sine_oscillator_glide_gain_ramp sogr_checker u_sogr_checker (.*);
